/* sv/usc_pkg.sv */
// Shared types, constants and ones' complement helper for the UDP segment checker.
// No dependencies; every other file imports this package.
`default_nettype none

package usc_pkg;

  localparam logic [15:0] HDR_LEN   = 16'd8;
  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] SUM_GOOD  = 16'hFFFF;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_CSUM   = 2'd1;
  localparam logic [1:0] ST_WRONG_PORT = 2'd2;
  localparam logic [1:0] ST_BAD_LEN    = 2'd3;

  typedef struct packed {
    logic [7:0]  seg_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } seg_t;

  typedef struct packed {
    logic        emit;
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] seg_length;
    logic [15:0] src_port;
    logic [15:0] dest_port;
  } result_t;

  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    u = {1'b0, t[15:0]} + {16'd0, t[16]};
    return u[15:0];
  endfunction

endpackage

`default_nettype wire

/* sv/usc_seg_if.sv */
// Byte channel carrying one segment byte and the pseudo header addresses.
// Depends on usc_pkg.
`default_nettype none

interface usc_seg_if;
  import usc_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  seg_byte;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;

  modport source (output valid, output seg_byte, output src_ip, output dst_ip, input ready);
  modport sink   (input valid, input seg_byte, input src_ip, input dst_ip, output ready);
endinterface

`default_nettype wire

/* sv/usc_res_if.sv */
// Result channel: payload byte pass-through and end-of-segment status.
// Depends on usc_pkg.
`default_nettype none

interface usc_res_if;
  import usc_pkg::*;

  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  payload_byte;
  logic        last;
  logic [1:0]  status;
  logic [15:0] seg_length;
  logic [15:0] src_port;
  logic [15:0] dest_port;

  modport source (output valid, output has_byte, output payload_byte, output last,
                  output status, output seg_length, output src_port, output dest_port,
                  input ready);
  modport sink   (input valid, input has_byte, input payload_byte, input last,
                  input status, input seg_length, input src_port, input dest_port,
                  output ready);
endinterface

`default_nettype wire

/* sv/usc_core.sv */
// Segment state and checksum datapath: one byte per transfer, result formed combinationally.
// Depends on usc_pkg.
`default_nettype none

module usc_core
  import usc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  seg_t        seg,
  input  logic [15:0] local_port,
  output result_t     res
);

  logic [15:0] byte_pos;
  logic [15:0] total_len;
  logic [15:0] sum_acc;
  logic [7:0]  high_byte;
  logic [15:0] src_port_reg;
  logic [15:0] dest_port_reg;

  logic [15:0] byte_pos_next;
  logic [15:0] total_len_next;
  logic [15:0] sum_acc_next;
  logic [7:0]  high_byte_next;
  logic [15:0] src_port_next;
  logic [15:0] dest_port_next;

  logic [15:0] word;
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [18:0] init_raw;
  logic [18:0] sum_raw;
  logic        odd;
  logic        short_len;
  logic        is_last;
  logic        has;

  always_comb begin
    odd       = byte_pos[0];
    word      = {high_byte, seg.seg_byte};
    short_len = total_len < HDR_LEN;
    is_last   = (byte_pos >= (HDR_LEN - 16'd1)) &&
                (short_len || (({1'b0, byte_pos} + 17'd1) == {1'b0, total_len}));
    has       = (byte_pos >= HDR_LEN) && !short_len;

    init_raw = {3'd0, seg.src_ip[31:16]} + {3'd0, seg.src_ip[15:0]} +
               {3'd0, seg.dst_ip[31:16]} + {3'd0, seg.dst_ip[15:0]} +
               {3'd0, UDP_PROTO};

    if (odd) begin
      add_a = word;
    end else if (is_last) begin
      add_a = {seg.seg_byte, 8'd0};
    end else begin
      add_a = 16'd0;
    end
    add_b   = (byte_pos == 16'd5) ? word : 16'd0;
    sum_raw = {3'd0, sum_acc} + {3'd0, add_a} + {3'd0, add_b};

    sum_acc_next   = (byte_pos == 16'd0) ? oc_fold(init_raw) : oc_fold(sum_raw);
    high_byte_next = odd ? high_byte : seg.seg_byte;
    src_port_next  = (byte_pos == 16'd1) ? word : src_port_reg;
    dest_port_next = (byte_pos == 16'd3) ? word : dest_port_reg;
    total_len_next = (byte_pos == 16'd5) ? word : total_len;
    byte_pos_next  = is_last ? 16'd0 : byte_pos + 16'd1;

    res              = '0;
    res.emit         = is_last || has;
    res.has_byte     = has;
    res.payload_byte = has ? seg.seg_byte : 8'd0;
    res.last         = is_last;
    if (is_last) begin
      res.seg_length = total_len;
      res.src_port   = src_port_reg;
      res.dest_port  = dest_port_reg;
      if (short_len) begin
        res.status = ST_BAD_LEN;
      end else if (sum_acc_next != SUM_GOOD) begin
        res.status = ST_BAD_CSUM;
      end else if (dest_port_reg != local_port) begin
        res.status = ST_WRONG_PORT;
      end else begin
        res.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= 16'd0;
      total_len     <= 16'd0;
      sum_acc       <= 16'd0;
      high_byte     <= 8'd0;
      src_port_reg  <= 16'd0;
      dest_port_reg <= 16'd0;
    end else if (fire) begin
      byte_pos      <= byte_pos_next;
      total_len     <= total_len_next;
      sum_acc       <= sum_acc_next;
      high_byte     <= high_byte_next;
      src_port_reg  <= src_port_next;
      dest_port_reg <= dest_port_next;
    end
  end

`ifndef SYNTH
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && res.last |=> byte_pos == 16'd0)
    else $error("segment end did not restart byte offset");

  a_pos_advances: assert property (@(posedge clk) disable iff (rst)
    fire && !res.last |=> byte_pos == $past(byte_pos) + 16'd1)
    else $error("byte offset did not advance");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status != ST_OK) |-> res.last)
    else $error("status set outside segment end");

  a_payload_past_header: assert property (@(posedge clk) disable iff (rst)
    fire && res.has_byte |-> byte_pos >= HDR_LEN && total_len >= HDR_LEN)
    else $error("payload byte inside header");
`endif

endmodule

`default_nettype wire

/* sv/udp_segment_checker.sv */
// Top level: APB local port register, segment channel, registered result channel.
// Depends on usc_pkg, usc_seg_if, usc_res_if and usc_core.
`default_nettype none

// Takes one UDP segment byte per cycle, with the IPv4 addresses sampled on
// the first byte, and returns a result in the next cycle from a single output
// register: one result per payload byte and one on the final byte with status
// (0 ok, 1 bad checksum, 2 wrong port, 3 bad length; bad length has precedence,
// then bad checksum, then wrong port). Header bytes give no result. The
// sustained rate is one byte per cycle, set by the ones' complement add and fold
// on the running sum; the input stalls only while a result waits at the output.
// Payload is streamed, so the consumer drops it when the final status is not ok.
// Program local_port (byte address 0) while no segment is in flight.
module udp_segment_checker
  import usc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  usc_seg_if.sink     segment,
  usc_res_if.source   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] local_port;
  logic        fire;
  logic        out_valid;
  seg_t        seg;
  result_t     core_res;
  result_t     out_res;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, local_port};

  always_ff @(posedge clk) begin
    if (rst) begin
      local_port <= 16'd0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      local_port <= pwdata[15:0];
    end
  end

  assign segment.ready = !out_valid || result.ready;
  assign fire          = segment.valid && segment.ready;

  assign seg.seg_byte = segment.seg_byte;
  assign seg.src_ip   = segment.src_ip;
  assign seg.dst_ip   = segment.dst_ip;

  usc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .seg        (seg),
    .local_port (local_port),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= core_res.emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= core_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.has_byte     = out_res.has_byte;
  assign result.payload_byte = out_res.payload_byte;
  assign result.last         = out_res.last;
  assign result.status       = out_res.status;
  assign result.seg_length   = out_res.seg_length;
  assign result.src_port     = out_res.src_port;
  assign result.dest_port    = out_res.dest_port;

`ifndef SYNTH
  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    fire && core_res.emit |=> out_valid)
    else $error("result transfer lost");

  a_silent_byte_clears: assert property (@(posedge clk) disable iff (rst)
    fire && !core_res.emit |=> !out_valid)
    else $error("result repeated after header byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !fire)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
